// ===== sv/atc_pkg.sv =====
`default_nettype none
package atc_pkg;

  localparam int ANGLE_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int VAL_W          = 32;
  localparam int PROD_W         = 2 * VAL_W;
  localparam int ACC_W          = PROD_W + 2;
  localparam int DIM            = 4;
  localparam int IDX_W          = 2;
  localparam int CNT_W          = 2 * IDX_W;
  localparam int DRAIN_CYCLES   = 3;

  typedef enum logic [2:0] {
    MODE_IDENT = 3'd0,
    MODE_ROT_X = 3'd1,
    MODE_ROT_Y = 3'd2,
    MODE_ROT_Z = 3'd3,
    MODE_TRANS = 3'd4,
    MODE_SCALE = 3'd5,
    MODE_READ  = 3'd6
  } atc_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_CALC,
    ST_DRAIN,
    ST_READ
  } atc_state_t;

  typedef struct packed {
    logic ident;
    logic rotate;
    logic issue;
    logic first;
    logic last;
    logic commit;
  } atc_lane_ctl_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } atc_emit_t;

endpackage
`default_nettype wire

// ===== sv/affine_transform_composer.sv =====
// Affine transform composer. Holds a 4x4 signed fixed-point matrix and composes
// elementary transforms onto it.
// The input channel (in_valid, in_stall) carries a mode with an angle and three
// operands. Rotations, translate and scale replace the matrix M with N*M. No
// further transfer is taken until one is complete: the transfer cycle reads the
// sine table, the trig state folds the quadrant, a multiply-accumulate state
// follows in which four column lanes each work one row term per cycle, and a
// drain state empties the lane pipeline.
// An identity transfer or an unused mode is completed in the idle state.
// A read transfer streams all sixteen elements in row-major order on the output
// channel (out_valid, out_stall), one per cycle unless out_stall holds it, with
// out_last on the final one. The first element is emitted from the read state
// into the output register, which holds its element while out_stall is high;
// no further transfer is taken until the last element of a read has been sent.
// Synchronous reset (rst_n low) loads the identity matrix and empties the
// output register.
`default_nettype none
module affine_transform_composer #(
  parameter int ANGLE_BITS = atc_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = atc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [2:0]                         in_mode,
  input  wire logic [ANGLE_BITS-1:0]              in_angle,
  input  wire logic signed [atc_pkg::VAL_W-1:0]   in_operand_x,
  input  wire logic signed [atc_pkg::VAL_W-1:0]   in_operand_y,
  input  wire logic signed [atc_pkg::VAL_W-1:0]   in_operand_z,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [atc_pkg::IDX_W-1:0]               out_row,
  output logic [atc_pkg::IDX_W-1:0]               out_column,
  output logic signed [atc_pkg::VAL_W-1:0]        out_value,
  output logic                                    out_last
);
  import atc_pkg::*;

  logic                    trig_cap;
  logic                    trig_load;
  logic signed [VAL_W-1:0] sin_val;
  logic signed [VAL_W-1:0] cos_val;
  atc_lane_ctl_t           lane_ctl;
  logic signed [VAL_W-1:0] n_val;
  atc_emit_t               emit;
  logic                    out_free;
  logic signed [VAL_W-1:0] head [DIM];

  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_row_r;
  logic [IDX_W-1:0]        out_col_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_last_r;

  assign out_free = !out_valid_r || !out_stall;

  atc_trig #(
    .ANGLE_BITS (ANGLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_trig (
    .clk     (clk),
    .angle   (in_angle),
    .cap     (trig_cap),
    .load    (trig_load),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  atc_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_operand_x (in_operand_x),
    .in_operand_y (in_operand_y),
    .in_operand_z (in_operand_z),
    .sin_val      (sin_val),
    .cos_val      (cos_val),
    .out_free     (out_free),
    .trig_cap     (trig_cap),
    .trig_load    (trig_load),
    .lane_ctl     (lane_ctl),
    .n_val        (n_val),
    .emit         (emit)
  );

  for (genvar g = 0; g < DIM; g++) begin : g_lane
    atc_lane #(
      .LANE      (g),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lane_ctl),
      .n_val (n_val),
      .head  (head[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_row_r   <= emit.row;
      out_col_r   <= emit.col;
      out_value_r <= head[emit.col];
      out_last_r  <= emit.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_row    = out_row_r;
  assign out_column = out_col_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

// ===== sv/atc_trig.sv =====
`default_nettype none
module atc_trig #(
  parameter int ANGLE_BITS = atc_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = atc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic [ANGLE_BITS-1:0]          angle,
  input  wire logic                           cap,
  input  wire logic                           load,
  output logic signed [atc_pkg::VAL_W-1:0]    sin_val,
  output logic signed [atc_pkg::VAL_W-1:0]    cos_val
);
  import atc_pkg::*;

  localparam int QTR   = 1 << (ANGLE_BITS - 2);
  localparam int AW    = ANGLE_BITS - 1;
  localparam int TAB_W = FRAC_BITS + 1;
  localparam real PI   = 3.14159265358979323846;
  localparam real ANG_STEP = 2.0 * PI / (2.0 ** ANGLE_BITS);

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  typedef logic [TAB_W-1:0] tab_t [QTR+1];

  function automatic tab_t build_tab();
    tab_t t;
    real  ang;
    for (int i = 0; i <= QTR; i++) begin
      ang  = ANG_STEP * i;
      t[i] = TAB_W'($rtoi($floor($sin(ang) * (2.0 ** FRAC_BITS) + 0.5)));
    end
    return t;
  endfunction

  localparam tab_t SIN_TAB = build_tab();

  logic [AW-1:0]          addr_a;
  logic [AW-1:0]          addr_b;
  logic [TAB_W-1:0]       a_r;
  logic [TAB_W-1:0]       b_r;
  logic [1:0]             quad_r;
  logic signed [VAL_W-1:0] pa;
  logic signed [VAL_W-1:0] pb;
  logic signed [VAL_W-1:0] s_nxt;
  logic signed [VAL_W-1:0] c_nxt;
  logic signed [VAL_W-1:0] s_r;
  logic signed [VAL_W-1:0] c_r;

  assign addr_a = {1'b0, angle[ANGLE_BITS-3:0]};
  assign addr_b = AW'(QTR) - addr_a;

  always_ff @(posedge clk) begin
    if (cap) begin
      a_r    <= SIN_TAB[addr_a];
      b_r    <= SIN_TAB[addr_b];
      quad_r <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
    end
  end

  assign pa = {{(VAL_W-TAB_W){1'b0}}, a_r};
  assign pb = {{(VAL_W-TAB_W){1'b0}}, b_r};

  always_comb begin
    case (quad_r)
      QUAD_I: begin
        s_nxt = pa;
        c_nxt = pb;
      end
      QUAD_II: begin
        s_nxt = pb;
        c_nxt = -pa;
      end
      QUAD_III: begin
        s_nxt = -pa;
        c_nxt = -pb;
      end
      default: begin
        s_nxt = -pb;
        c_nxt = pa;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s_r <= s_nxt;
      c_r <= c_nxt;
    end
  end

  assign sin_val = s_r;
  assign cos_val = c_r;

endmodule
`default_nettype wire

// ===== sv/atc_lane.sv =====
`default_nettype none
module atc_lane #(
  parameter int LANE      = 0,
  parameter int FRAC_BITS = atc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire atc_pkg::atc_lane_ctl_t             ctl,
  input  wire logic signed [atc_pkg::VAL_W-1:0]   n_val,
  output logic signed [atc_pkg::VAL_W-1:0]        head
);
  import atc_pkg::*;

  localparam logic signed [VAL_W-1:0] ONE     = VAL_W'(1) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic signed [VAL_W-1:0]  col_r [DIM];
  logic signed [VAL_W-1:0]  col_nxt [DIM];
  logic signed [VAL_W-1:0]  res_r [DIM];
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-VAL_W:0]     hi;
  logic signed [VAL_W-1:0]  sat;
  logic                     a_vld_r;
  logic                     a_first_r;
  logic                     a_last_r;
  logic                     b_vld_r;

  assign head = col_r[0];

  always_comb begin
    for (int q = 0; q < DIM; q++) begin
      if (ctl.ident) begin
        col_nxt[q] = (q == LANE) ? ONE : '0;
      end else if (ctl.commit) begin
        col_nxt[q] = res_r[q];
      end else if (ctl.rotate) begin
        col_nxt[q] = col_r[IDX_W'(q + 1)];
      end else begin
        col_nxt[q] = col_r[q];
      end
    end
  end

  assign acc_nxt = (a_first_r ? '0 : acc_r) + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  assign shifted = acc_r >>> FRAC_BITS;
  assign hi      = shifted[ACC_W-1:VAL_W-1];
  assign sat     = (&hi || ~|hi) ? shifted[VAL_W-1:0]
                 : (shifted[ACC_W-1] ? SAT_MIN : SAT_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < DIM; q++) begin
        col_r[q] <= (q == LANE) ? ONE : '0;
      end
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      for (int q = 0; q < DIM; q++) begin
        col_r[q] <= col_nxt[q];
      end
      a_vld_r <= ctl.issue;
      b_vld_r <= a_vld_r && a_last_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= n_val * col_r[0];
    a_first_r <= ctl.first;
    a_last_r  <= ctl.last;
    if (a_vld_r) begin
      acc_r <= acc_nxt;
    end
    if (b_vld_r) begin
      for (int q = 0; q < DIM - 1; q++) begin
        res_r[q] <= res_r[q+1];
      end
      res_r[DIM-1] <= sat;
    end
  end

endmodule
`default_nettype wire

// ===== sv/atc_ctrl.sv =====
`default_nettype none
module atc_ctrl #(
  parameter int FRAC_BITS = atc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [2:0]                         in_mode,
  input  wire logic signed [atc_pkg::VAL_W-1:0]   in_operand_x,
  input  wire logic signed [atc_pkg::VAL_W-1:0]   in_operand_y,
  input  wire logic signed [atc_pkg::VAL_W-1:0]   in_operand_z,
  input  wire logic signed [atc_pkg::VAL_W-1:0]   sin_val,
  input  wire logic signed [atc_pkg::VAL_W-1:0]   cos_val,
  input  wire logic                               out_free,
  output logic                                    trig_cap,
  output logic                                    trig_load,
  output atc_pkg::atc_lane_ctl_t                  lane_ctl,
  output logic signed [atc_pkg::VAL_W-1:0]        n_val,
  output atc_pkg::atc_emit_t                      emit
);
  import atc_pkg::*;

  localparam logic signed [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0] CNT_LAST   = {CNT_W{1'b1}};
  localparam logic [IDX_W-1:0] IDX_LAST   = {IDX_W{1'b1}};

  atc_state_t              state_r;
  atc_state_t              state_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        cnt_nxt;
  atc_mode_t               mode_in;
  atc_mode_t               mode_r;
  logic signed [VAL_W-1:0] ox_r;
  logic signed [VAL_W-1:0] oy_r;
  logic signed [VAL_W-1:0] oz_r;
  logic                    accept;

  function automatic logic signed [VAL_W-1:0] n_elem(
    input atc_mode_t               mode,
    input logic [CNT_W-1:0]        idx,
    input logic signed [VAL_W-1:0] s,
    input logic signed [VAL_W-1:0] c,
    input logic signed [VAL_W-1:0] x,
    input logic signed [VAL_W-1:0] y,
    input logic signed [VAL_W-1:0] z
  );
    logic signed [VAL_W-1:0] v;
    v = (idx[CNT_W-1:IDX_W] == idx[IDX_W-1:0]) ? ONE : '0;
    case (mode)
      MODE_ROT_X: begin
        if (idx == 4'd5 || idx == 4'd10) v = c;
        if (idx == 4'd6) v = s;
        if (idx == 4'd9) v = -s;
      end
      MODE_ROT_Y: begin
        if (idx == 4'd0 || idx == 4'd10) v = c;
        if (idx == 4'd2) v = -s;
        if (idx == 4'd8) v = s;
      end
      MODE_ROT_Z: begin
        if (idx == 4'd0 || idx == 4'd5) v = c;
        if (idx == 4'd1) v = s;
        if (idx == 4'd4) v = -s;
      end
      MODE_TRANS: begin
        if (idx == 4'd12) v = x;
        if (idx == 4'd13) v = y;
        if (idx == 4'd14) v = z;
      end
      MODE_SCALE: begin
        if (idx == 4'd0) v = x;
        if (idx == 4'd5) v = y;
        if (idx == 4'd10) v = z;
      end
      default: begin
        v = v;
      end
    endcase
    return v;
  endfunction

  assign mode_in = atc_mode_t'(in_mode);
  assign accept  = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (mode_in)
            MODE_ROT_X, MODE_ROT_Y, MODE_ROT_Z, MODE_TRANS, MODE_SCALE: begin
              state_nxt = ST_TRIG;
            end
            MODE_READ: begin
              state_nxt = ST_READ;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
          cnt_nxt = '0;
        end
      end
      ST_TRIG: begin
        state_nxt = ST_CALC;
        cnt_nxt   = '0;
      end
      ST_CALC: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_DRAIN;
          cnt_nxt   = '0;
        end
      end
      ST_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DRAIN_CYCLES - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_READ: begin
        if (out_free) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    trig_cap  = 1'b0;
    trig_load = 1'b0;
    lane_ctl  = '0;
    emit      = '0;
    emit.row  = cnt_r[CNT_W-1:IDX_W];
    emit.col  = cnt_r[IDX_W-1:0];
    emit.last = (cnt_r == CNT_LAST);
    n_val     = n_elem(mode_r, cnt_r, sin_val, cos_val, ox_r, oy_r, oz_r);
    case (state_r)
      ST_IDLE: begin
        in_stall       = 1'b0;
        trig_cap       = in_valid;
        lane_ctl.ident = in_valid && (mode_in == MODE_IDENT);
      end
      ST_TRIG: begin
        trig_load = 1'b1;
      end
      ST_CALC: begin
        lane_ctl.issue  = 1'b1;
        lane_ctl.rotate = 1'b1;
        lane_ctl.first  = (cnt_r[IDX_W-1:0] == '0);
        lane_ctl.last   = (cnt_r[IDX_W-1:0] == IDX_LAST);
      end
      ST_DRAIN: begin
        lane_ctl.commit = (cnt_r == CNT_W'(DRAIN_CYCLES - 1));
      end
      ST_READ: begin
        emit.valid      = out_free;
        lane_ctl.rotate = out_free && (cnt_r[IDX_W-1:0] == IDX_LAST);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode_in;
      ox_r   <= in_operand_x;
      oy_r   <= in_operand_y;
      oz_r   <= in_operand_z;
    end
  end

  a_compose_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (mode_in == MODE_ROT_X || mode_in == MODE_ROT_Y || mode_in == MODE_ROT_Z ||
               mode_in == MODE_TRANS || mode_in == MODE_SCALE)
    |=> state_r == ST_TRIG)
    else $error("Update transfer did not start the table lookup.");

  a_commit_timing: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ctl.issue && cnt_r == CNT_LAST |=> ##2 lane_ctl.commit)
    else $error("Matrix commit is not aligned with the lane pipeline.");

  a_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid && emit.last |=> state_r == ST_IDLE && !lane_ctl.rotate)
    else $error("Read burst did not end after its last element.");

  a_read_rotate: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ && lane_ctl.rotate |-> emit.valid && emit.col == IDX_LAST)
    else $error("Columns rotated before a row was fully sent.");

endmodule
`default_nettype wire
